/* rtl/http_header_tokenizer_core_assert.svh */
// Assertion macros shared by the HTTP header tokenizer RTL.
// Depends on a clock named clock and a synchronous reset named reset in the including scope.
`ifndef HTTP_HEADER_TOKENIZER_CORE_ASSERT_SVH
`define HTTP_HEADER_TOKENIZER_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define HTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define HTT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/htt_pkg.sv */
// Shared constants and types of the HTTP header tokenizer.
// Used by htt_parse_step and http_header_tokenizer_core; no dependencies.
package htt_pkg;

   localparam int PhaseW = 4;
   localparam int CountW = 16;
   localparam int ClassW = 3;

   localparam logic [PhaseW-1:0] PH_START  = 4'd0;
   localparam logic [PhaseW-1:0] PH_KEY    = 4'd1;
   localparam logic [PhaseW-1:0] PH_COLON  = 4'd2;
   localparam logic [PhaseW-1:0] PH_SPACE  = 4'd3;
   localparam logic [PhaseW-1:0] PH_VALUE  = 4'd4;
   localparam logic [PhaseW-1:0] PH_CR     = 4'd5;
   localparam logic [PhaseW-1:0] PH_LF     = 4'd6;
   localparam logic [PhaseW-1:0] PH_END_CR = 4'd7;
   localparam logic [PhaseW-1:0] PH_BODY   = 4'd8;
   localparam logic [PhaseW-1:0] PH_ERROR  = 4'd9;

   localparam logic [ClassW-1:0] CL_IGNORED = 3'd0;
   localparam logic [ClassW-1:0] CL_KEY     = 3'd1;
   localparam logic [ClassW-1:0] CL_SEP     = 3'd2;
   localparam logic [ClassW-1:0] CL_VALUE   = 3'd3;
   localparam logic [ClassW-1:0] CL_LINE    = 3'd4;
   localparam logic [ClassW-1:0] CL_HDONE   = 3'd5;
   localparam logic [ClassW-1:0] CL_BODY    = 3'd6;
   localparam logic [ClassW-1:0] CL_ERROR   = 3'd7;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [CountW-1:0] SPAN_RESET = 16'd255;
   localparam logic [CountW-1:0] COUNT_MAX  = 16'hFFFF;

   // Outcome of one byte: next parser state and the classification.
   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [CountW-1:0] offset;
      logic [ClassW-1:0] byte_class;
      logic [CountW-1:0] value_count;
   } step_type;

endpackage

/* rtl/htt_parse_step.sv */
// Next-state and classification logic of the tokenizer for one byte.
// Depends on htt_pkg.
module htt_parse_step (
   input  logic [htt_pkg::PhaseW-1:0] phase,
   input  logic [htt_pkg::CountW-1:0] offset,
   input  logic [htt_pkg::CountW-1:0] max_span,
   input  logic [7:0]                 data_byte,
   input  logic                       restart,
   output htt_pkg::step_type          step
);
   import htt_pkg::*;

   logic [PhaseW-1:0] cur_phase;
   logic [CountW-1:0] cur_off;
   logic [CountW-1:0] off_inc;
   logic [CountW-1:0] new_off;
   logic [CountW-1:0] new_inc;
   logic [PhaseW-1:0] next_phase;
   logic [ClassW-1:0] cls;
   logic              is_colon, is_space, is_cr, is_lf;

   assign cur_phase = restart ? PH_START : phase;
   assign cur_off   = restart ? '0 : offset;
   assign off_inc   = (cur_off == COUNT_MAX) ? COUNT_MAX : cur_off + 16'd1;
   assign is_colon  = (data_byte == CH_COLON);
   assign is_space  = (data_byte == CH_SPACE);
   assign is_cr     = (data_byte == CH_CR);
   assign is_lf     = (data_byte == CH_LF);

   always_comb begin
      next_phase = PH_ERROR;
      cls        = CL_ERROR;
      new_off    = cur_off;
      unique case (cur_phase)
         PH_START: begin
            if (is_cr || is_lf) begin
               cls = CL_IGNORED; next_phase = PH_START;
            end else if (!is_colon) begin
               cls = CL_KEY; next_phase = PH_KEY; new_off = '0;
            end
         end
         PH_KEY: begin
            if (is_colon) begin
               cls = CL_SEP; next_phase = PH_COLON;
            end else if (!is_cr && !is_lf) begin
               cls = CL_KEY; next_phase = PH_KEY;
            end
         end
         PH_COLON: begin
            if (is_space) begin
               cls = CL_SEP; next_phase = PH_SPACE;
            end
         end
         PH_SPACE: begin
            cls = CL_VALUE; next_phase = PH_VALUE; new_off = '0;
         end
         PH_VALUE: begin
            if (is_cr) begin
               cls = CL_LINE; next_phase = PH_CR;
            end else if (off_inc <= max_span) begin
               cls = CL_VALUE; next_phase = PH_VALUE; new_off = off_inc;
            end
         end
         PH_CR: begin
            if (is_lf) begin
               cls = CL_LINE; next_phase = PH_LF;
            end
         end
         PH_LF: begin
            if (is_cr) begin
               cls = CL_HDONE; next_phase = PH_END_CR;
            end else if (!is_colon && !is_lf) begin
               cls = CL_KEY; next_phase = PH_KEY; new_off = '0;
            end
         end
         PH_END_CR: begin
            if (is_lf) begin
               cls = CL_HDONE; next_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            cls = CL_BODY; next_phase = PH_BODY;
         end
         default: begin
            // Error phase and unused codes stay in error.
            next_phase = PH_ERROR;
            cls        = CL_ERROR;
         end
      endcase
   end

   assign new_inc = (new_off == COUNT_MAX) ? COUNT_MAX : new_off + 16'd1;

   always_comb begin
      step.phase      = next_phase;
      step.offset     = new_off;
      step.byte_class = cls;
      if (next_phase == PH_VALUE || next_phase == PH_CR || next_phase == PH_LF) begin
         step.value_count = new_inc;
      end else begin
         step.value_count = '0;
      end
   end

endmodule

/* rtl/http_header_tokenizer_core.sv */
// Top level of the HTTP header tokenizer: stream ports, parser state and result register.
// Depends on htt_pkg, htt_parse_step and http_header_tokenizer_core_assert.svh.
`include "http_header_tokenizer_core_assert.svh"

// The tokenizer takes one header byte per item and returns exactly one result item per
// byte, labeling it ignored, key, separator, value, line done, headers done, body or
// error, together with the byte itself and the running count of value bytes. It takes a
// new item in every cycle: the parser state lives in two small registers that update at
// the accepting edge, and the result is loaded into an output register at that same edge,
// so the throughput is one byte per cycle as long as the result side keeps taking items.
// The input is ready whenever the output register is empty or is being emptied in the
// same cycle. An error is sticky; only an item with the restart flag set (or reset)
// brings the parser back to the start state, and restart acts before the byte it comes
// with is classified. The span limit is written through csr_we/csr_wdata and should
// only change while no items are in flight; it resets to 255.
module http_header_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] echo_byte, [23:8] value_count
   output logic [2:0]  rsp_tuser,   // [2:0] byte_class
   // Span limit register.
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // [15:0] max_value_span
);
   import htt_pkg::*;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [CountW-1:0] offset_ff, offset_in;
   logic [CountW-1:0] span_ff, span_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ClassW-1:0] rsp_class_ff, rsp_class_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic              accept;
   step_type          step;

   // The output register frees up in the same cycle its item is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   htt_parse_step u_step (
      .phase     (phase_ff),
      .offset    (offset_ff),
      .max_span  (span_ff),
      .data_byte (req_tdata),
      .restart   (req_tuser),
      .step      (step)
   );

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      rsp_class_in = rsp_class_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_count_in = rsp_count_ff;
      span_in      = csr_we ? csr_wdata : span_ff;
      if (accept) begin
         phase_in     = step.phase;
         offset_in    = step.offset;
         rsp_class_in = step.byte_class;
         rsp_byte_in  = req_tdata;
         rsp_count_in = step.value_count;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         offset_ff    <= '0;
         span_ff      <= SPAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_class_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_byte_ff};

   // Once in error, only a restart item can leave it.
   `HTT_ASSERT_NEXT(a_error_sticky, accept && !req_tuser && phase_ff == PH_ERROR, phase_ff == PH_ERROR && rsp_tuser == CL_ERROR, "error phase left without restart")
   // After the empty line every byte is body.
   `HTT_ASSERT_NEXT(a_body_class, accept && !req_tuser && phase_ff == PH_BODY, rsp_tuser == CL_BODY, "byte after headers not marked as body")
   // An accepted item always shows up in the output register the next cycle.
   `HTT_ASSERT_NEXT(a_result_loaded, accept, rsp_valid_ff && rsp_byte_ff == $past(req_tdata), "accepted item missing from result register")
   // Error and key results never carry a value count.
   `HTT_ASSERT_SAME(a_count_zero, rsp_valid_ff && (rsp_class_ff == CL_ERROR || rsp_class_ff == CL_KEY), rsp_count_ff == '0, "nonzero count outside a value")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for http_header_tokenizer_core: drives header bytes in and checks
// each classified result against a cycle-free predictor of the parser. Depends on htt_pkg.

module tb_top;
   import htt_pkg::*;

   // The longest run of cycles in which nothing moves on either side before the run is
   // declared hung; the slowest correct case is a long receiver hold-off.
   localparam int StallLimit = 1000;

   // One outgoing byte and the restart flag that travels with it.
   typedef struct packed {
      logic       restart;
      logic [7:0] data;
   } feed_type;

   // One classified byte as the block reports it.
   typedef struct packed {
      logic [ClassW-1:0] byte_class;
      logic [7:0]        echo_byte;
      logic [CountW-1:0] value_count;
   } token_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [15:0] csr_wdata;

   // Predicted parser state, kept in step with the block at each accepting edge.
   logic [PhaseW-1:0] model_phase;
   logic [CountW-1:0] model_offset;
   logic [CountW-1:0] model_span;

   token_type   pending_tokens[$];   // classifications still owed by the block, oldest first
   feed_type    byte_feed[$];        // bytes built by a test and not yet sent
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          items_sent = 0;
   int          hold_cycles = 0;     // receiver hold-off requested by the pressure test
   bit          idling_on = 1'b1;

   http_header_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predicts the result of one byte and advances the predicted parser state. A restart
   // takes effect before the byte is looked at, and the span register is left alone.
   function automatic token_type classify_byte(input logic [7:0] b, input logic restart);
      token_type         t;
      logic [PhaseW-1:0] nxt;
      logic [ClassW-1:0] cls;
      logic [CountW-1:0] bumped;
      if (restart) begin
         model_phase  = PH_START;
         model_offset = '0;
      end
      nxt = PH_ERROR;
      cls = CL_ERROR;
      case (model_phase)
         PH_START: begin
            // Blank lines before the first key are skipped; a colon here is an error.
            if (b == CH_CR || b == CH_LF) begin
               cls = CL_IGNORED;
               nxt = PH_START;
            end else if (b != CH_COLON) begin
               cls = CL_KEY;
               nxt = PH_KEY;
               model_offset = '0;
            end
         end
         PH_KEY: begin
            if (b == CH_COLON) begin
               cls = CL_SEP;
               nxt = PH_COLON;
            end else if (b != CH_CR && b != CH_LF) begin
               cls = CL_KEY;
               nxt = PH_KEY;
            end
         end
         PH_COLON: begin
            if (b == CH_SPACE) begin
               cls = CL_SEP;
               nxt = PH_SPACE;
            end
         end
         PH_SPACE: begin
            // Whatever follows the single space opens the value, CR included.
            cls = CL_VALUE;
            nxt = PH_VALUE;
            model_offset = '0;
         end
         PH_VALUE: begin
            if (b == CH_CR) begin
               cls = CL_LINE;
               nxt = PH_CR;
            end else begin
               bumped = (model_offset != COUNT_MAX) ? model_offset + 16'd1 : COUNT_MAX;
               if (bumped <= model_span) begin
                  model_offset = bumped;
                  cls = CL_VALUE;
                  nxt = PH_VALUE;
               end
            end
         end
         PH_CR: begin
            if (b == CH_LF) begin
               cls = CL_LINE;
               nxt = PH_LF;
            end
         end
         PH_LF: begin
            // A CR where a key would start begins the empty line; an LF or colon is an error.
            if (b == CH_CR) begin
               cls = CL_HDONE;
               nxt = PH_END_CR;
            end else if (b != CH_COLON && b != CH_LF) begin
               cls = CL_KEY;
               nxt = PH_KEY;
               model_offset = '0;
            end
         end
         PH_END_CR: begin
            if (b == CH_LF) begin
               cls = CL_HDONE;
               nxt = PH_BODY;
            end
         end
         PH_BODY: begin
            cls = CL_BODY;
            nxt = PH_BODY;
         end
         default: ;
      endcase
      model_phase = nxt;
      t.byte_class = cls;
      t.echo_byte  = b;
      if (nxt == PH_VALUE || nxt == PH_CR || nxt == PH_LF) begin
         t.value_count = (model_offset != COUNT_MAX) ? model_offset + 16'd1 : COUNT_MAX;
      end else begin
         t.value_count = '0;
      end
      return t;
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] want,
                                  input logic [23:0] got);
      $display("%0t: mismatch on %s, expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Everything is sampled at the rising edge. Accepted bytes are predicted first, so the
   // check below would also hold if a result came back in the same cycle.
   always @(posedge clock) begin : scoreboard
      token_type got;
      token_type want;
      bit        moved;
      if (reset) begin
         model_phase  = PH_START;
         model_offset = '0;
         model_span   = SPAN_RESET;
         pending_tokens.delete();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_we) begin
            model_span = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            pending_tokens.push_back(classify_byte(req_tdata, req_tuser));
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.byte_class  = rsp_tuser;
            got.echo_byte   = rsp_tdata[7:0];
            got.value_count = rsp_tdata[23:8];
            if (pending_tokens.size() == 0) begin
               report_mismatch("result with nothing pending", 24'h0, rsp_tdata);
            end else begin
               want = pending_tokens.pop_front();
               if (got.byte_class !== want.byte_class) begin
                  report_mismatch("byte_class", 24'(want.byte_class), 24'(got.byte_class));
               end
               if (got.echo_byte !== want.echo_byte) begin
                  report_mismatch("echo_byte", 24'(want.echo_byte), 24'(got.echo_byte));
               end
               if (got.value_count !== want.value_count) begin
                  report_mismatch("value_count", 24'(want.value_count), 24'(got.value_count));
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // The receiver mostly takes results at once, stalls in short random bursts while idling
   // is on, and holds off for a long stretch when the pressure test asks for it.
   initial begin : rsp_ready_driver
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) begin
               stall = $urandom_range(1, 14);
            end
         end
      end
   end

   // Ends a hung run: nothing has moved on either side for too long.
   initial begin : watchdog
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Offers one byte from a falling edge and returns at the falling edge after it was
   // taken. The valid stays high so that back-to-back bytes leave no gap while idling is off.
   task automatic send_byte(input feed_type item);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item.data;
      req_tuser  <= item.restart;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_feed();
      while (byte_feed.size() != 0) send_byte(byte_feed.pop_front());
   endtask

   // Changes the span only with the block drained; one result per byte means an empty
   // prediction queue leaves nothing in flight.
   task automatic write_span(input logic [15:0] span);
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= span;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic void feed_byte(input logic [7:0] b, input logic restart);
      feed_type f;
      f.restart = restart;
      f.data    = b;
      byte_feed.push_back(f);
   endfunction

   function automatic logic [7:0] key_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_COLON || b == CH_CR || b == CH_LF);
      return b;
   endfunction

   function automatic logic [7:0] value_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
      return b;
   endfunction

   // A well-formed header line: random key, colon, space, a value of the given length whose
   // first byte may be anything, then CR LF.
   function automatic void feed_line(input int value_len, input logic restart);
      logic rst;
      rst = restart;
      repeat ($urandom_range(1, 4)) begin
         feed_byte(key_byte(), rst);
         rst = 1'b0;
      end
      feed_byte(CH_COLON, 1'b0);
      feed_byte(CH_SPACE, 1'b0);
      feed_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (value_len - 1) feed_byte(value_byte(), 1'b0);
      feed_byte(CH_CR, 1'b0);
      feed_byte(CH_LF, 1'b0);
   endfunction

   // Mostly complete header sections with random content; some get one byte corrupted and
   // some are replaced by plain noise with stray restarts.
   function automatic void feed_message();
      logic rst;
      int   pos;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(3, 10)) begin
            feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end else begin
         rst = ($urandom_range(0, 7) != 0);
         repeat ($urandom_range(0, 2)) begin
            feed_byte($urandom_range(0, 1) ? CH_CR : CH_LF, rst);
            rst = 1'b0;
         end
         repeat ($urandom_range(1, 3)) begin
            feed_line(($urandom_range(0, 7) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 6), rst);
            rst = 1'b0;
         end
         feed_byte(CH_CR, 1'b0);
         feed_byte(CH_LF, 1'b0);
         repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, byte_feed.size() - 1);
            byte_feed[pos].data = 8'($urandom_range(0, 255));
         end
      end
   endfunction

   // Leading blank bytes, a key and value at the byte extremes, a value that opens with CR,
   // the empty line and a few body bytes.
   task automatic test_clean_header();
      feed_byte(CH_CR, 1'b1);
      feed_byte(CH_LF, 1'b0);
      feed_byte(8'h00, 1'b0);
      feed_byte(8'hFF, 1'b0);
      feed_byte(CH_COLON, 1'b0);
      feed_byte(CH_SPACE, 1'b0);
      feed_byte(CH_CR, 1'b0);
      feed_byte(8'hFF, 1'b0);
      feed_byte(8'h00, 1'b0);
      feed_byte(CH_CR, 1'b0);
      feed_byte(CH_LF, 1'b0);
      feed_byte(CH_CR, 1'b0);
      feed_byte(CH_LF, 1'b0);
      feed_byte(8'hFF, 1'b0);
      feed_byte(CH_LF, 1'b0);
      send_feed();
   endtask

   // An empty key, an LF inside a key, and an LF where the next key would start followed by
   // a byte that must stay in the error state. Each case starts with a restart.
   task automatic test_malformed_headers();
      feed_byte(CH_COLON, 1'b1);
      feed_byte(8'h6B, 1'b1);
      feed_byte(CH_LF, 1'b0);
      feed_byte(8'h6B, 1'b1);
      feed_byte(CH_COLON, 1'b0);
      feed_byte(CH_SPACE, 1'b0);
      feed_byte(8'h76, 1'b0);
      feed_byte(CH_CR, 1'b0);
      feed_byte(CH_LF, 1'b0);
      feed_byte(CH_LF, 1'b0);
      feed_byte(8'h41, 1'b0);
      send_feed();
   endtask

   // Values one byte within the span and one byte past it, at a zero span and a small one,
   // then an unlimited span with a longer value sent at full rate.
   task automatic test_value_span();
      write_span(16'd0);
      feed_line(1, 1'b1);
      feed_line(2, 1'b1);
      send_feed();
      write_span(16'd3);
      feed_line(4, 1'b1);
      feed_line(5, 1'b1);
      send_feed();
      write_span(16'hFFFF);
      idling_on = 1'b0;
      feed_line(30, 1'b1);
      send_feed();
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [15:0] span, input int item_goal,
                                      input bit allow_idle);
      int first;
      write_span(span);
      first = items_sent;
      while (items_sent - first < item_goal) begin
         idling_on = allow_idle && ($urandom_range(0, 3) != 0);
         feed_message();
         send_feed();
      end
   endtask

   // The receiver holds off long enough for the output register to fill and the input to
   // stall while the sender keeps offering bytes.
   task automatic test_receiver_hold();
      idling_on = 1'b0;
      hold_cycles = 80;
      feed_line(12, 1'b1);
      send_feed();
      idling_on = 1'b1;
   endtask

   initial begin : test_sequence
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = 16'h0000;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_clean_header();
      test_malformed_headers();
      test_value_span();
      test_random_traffic(16'd4, 120, 1'b1);
      test_random_traffic(SPAN_RESET, 120, 1'b1);
      test_receiver_hold();
      // The last stretch runs at full rate on both sides.
      idling_on = 1'b0;
      test_random_traffic(16'd2, 60, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* http_header_tokenizer_core.f */
+incdir+rtl
rtl/htt_pkg.sv
rtl/htt_parse_step.sv
rtl/http_header_tokenizer_core.sv
tb/tb_top.sv
